[rtl/a51rc_pkg.sv]
// a51rc_pkg: shared types and constants of the a5/1 rainbow chain generator
package a51rc_pkg;

    localparam int VALUE_W = 64;
    localparam int LEN_W   = 24;
    localparam int R1_W    = 19;
    localparam int R2_W    = 22;
    localparam int R3_W    = 23;

    // slice offsets of the three registers within the chain value
    localparam int R1_LSB = 45;
    localparam int R2_LSB = 23;
    localparam int R3_LSB = 0;

    // feedback taps
    localparam logic [R1_W-1:0] R1_FB = 19'h72000;
    localparam logic [R2_W-1:0] R2_FB = 22'h300000;
    localparam logic [R3_W-1:0] R3_FB = 23'h700080;

    // clocking bits
    localparam logic [R1_W-1:0] R1_CLK = 19'h00100;
    localparam logic [R2_W-1:0] R2_CLK = 22'h000400;
    localparam logic [R3_W-1:0] R3_CLK = 23'h000400;

    localparam logic [LEN_W-1:0] LEN_RESET = 24'd2097152;

    localparam int CLOCKS_PER_LINK = 63;
    localparam int STEP_W          = 6;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CLOCKS_PER_LINK - 1);

    typedef struct packed {
        logic start;      // take the start value and chain length
        logic load_link;  // decrement the link number and load the registers
        logic clock_step; // one majority clock and one keystream bit
        logic store_out;  // move the chain value to the output register
    } cmd_t;

    typedef struct packed {
        logic n_zero;     // no links left
        logic last_step;  // current clock is the last one of the link
    } sts_t;

endpackage

[rtl/a51rc_ctrl.sv]
// a51rc_ctrl: sequencing state machine and output valid of the chain generator
module a51rc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  a51rc_pkg::sts_t  sts,
    output a51rc_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CHECK  = 4'b0010,
        ST_RUN    = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.n_zero) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.load_link = 1'b1;
                    state_next    = ST_RUN;
                end
            end
            ST_RUN: begin
                cmd.clock_step = 1'b1;
                if (sts.last_step) begin
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.store_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.store_out) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[rtl/a51rc_datapath.sv]
// a51rc_datapath: chain value, link counter, a5/1 registers and output register
module a51rc_datapath (
    input  logic                             aclk,
    input  a51rc_pkg::cmd_t                  cmd,
    output a51rc_pkg::sts_t                  sts,
    input  logic [a51rc_pkg::VALUE_W-1:0]    start_value,
    input  logic [a51rc_pkg::LEN_W-1:0]      chain_length,
    output logic [a51rc_pkg::VALUE_W-1:0]    end_value
);

    logic [a51rc_pkg::VALUE_W-1:0] value_reg;
    logic [a51rc_pkg::VALUE_W-1:0] value_next;
    logic [a51rc_pkg::VALUE_W-1:0] ks_reg;
    logic [a51rc_pkg::VALUE_W-1:0] ks_next;
    logic [a51rc_pkg::VALUE_W-1:0] end_reg;
    logic [a51rc_pkg::LEN_W-1:0]   n_reg;
    logic [a51rc_pkg::LEN_W-1:0]   n_next;
    logic [a51rc_pkg::LEN_W-1:0]   link;
    logic [a51rc_pkg::STEP_W-1:0]  step_reg;
    logic [a51rc_pkg::STEP_W-1:0]  step_next;
    logic [a51rc_pkg::R1_W-1:0]    r1_reg;
    logic [a51rc_pkg::R1_W-1:0]    r1_next;
    logic [a51rc_pkg::R2_W-1:0]    r2_reg;
    logic [a51rc_pkg::R2_W-1:0]    r2_next;
    logic [a51rc_pkg::R3_W-1:0]    r3_reg;
    logic [a51rc_pkg::R3_W-1:0]    r3_next;
    logic                          c1;
    logic                          c2;
    logic                          c3;
    logic                          maj;
    logic                          ks_bit;

    assign link = n_reg - a51rc_pkg::LEN_W'(1);

    assign c1  = |(r1_reg & a51rc_pkg::R1_CLK);
    assign c2  = |(r2_reg & a51rc_pkg::R2_CLK);
    assign c3  = |(r3_reg & a51rc_pkg::R3_CLK);
    assign maj = (c1 & c2) | (c1 & c3) | (c2 & c3);

    always_comb begin
        r1_next    = r1_reg;
        r2_next    = r2_reg;
        r3_next    = r3_reg;
        n_next     = n_reg;
        step_next  = step_reg;
        value_next = value_reg;
        if (cmd.start) begin
            value_next = start_value;
            n_next     = chain_length;
        end
        if (cmd.load_link) begin
            n_next    = link;
            step_next = '0;
            r1_next   = value_reg[a51rc_pkg::R1_LSB +: a51rc_pkg::R1_W]
                        ^ link[a51rc_pkg::R1_W-1:0];
            r2_next   = value_reg[a51rc_pkg::R2_LSB +: a51rc_pkg::R2_W]
                        ^ link[a51rc_pkg::R2_W-1:0];
            r3_next   = value_reg[a51rc_pkg::R3_LSB +: a51rc_pkg::R3_W]
                        ^ link[a51rc_pkg::R3_W-1:0];
        end
        if (cmd.clock_step) begin
            step_next = step_reg + a51rc_pkg::STEP_W'(1);
            if (c1 == maj) begin
                r1_next = {r1_reg[a51rc_pkg::R1_W-2:0], ^(r1_reg & a51rc_pkg::R1_FB)};
            end
            if (c2 == maj) begin
                r2_next = {r2_reg[a51rc_pkg::R2_W-2:0], ^(r2_reg & a51rc_pkg::R2_FB)};
            end
            if (c3 == maj) begin
                r3_next = {r3_reg[a51rc_pkg::R3_W-2:0], ^(r3_reg & a51rc_pkg::R3_FB)};
            end
        end
    end

    // keystream bit from the registers as they stand after this cycle
    assign ks_bit = r1_next[a51rc_pkg::R1_W-1] ^ r2_next[a51rc_pkg::R2_W-1]
                    ^ r3_next[a51rc_pkg::R3_W-1];

    always_comb begin
        ks_next = ks_reg;
        if (cmd.load_link) begin
            ks_next = {{(a51rc_pkg::VALUE_W-1){1'b0}}, ks_bit};
        end else if (cmd.clock_step) begin
            ks_next = {ks_reg[a51rc_pkg::VALUE_W-2:0], ks_bit};
        end
    end

    always_ff @(posedge aclk) begin
        r1_reg   <= r1_next;
        r2_reg   <= r2_next;
        r3_reg   <= r3_next;
        ks_reg   <= ks_next;
        n_reg    <= n_next;
        step_reg <= step_next;
        if (cmd.clock_step && sts.last_step) begin
            value_reg <= ks_next;
        end else begin
            value_reg <= value_next;
        end
        if (cmd.store_out) begin
            end_reg <= value_reg;
        end
    end

    assign sts.n_zero    = (n_reg == '0);
    assign sts.last_step = (step_reg == a51rc_pkg::LAST_STEP);
    assign end_value     = end_reg;

endmodule

[rtl/a51_rainbow_chain.sv]
// a51_rainbow_chain: top level of the a5/1 rainbow chain generator
// One transaction carries a 64-bit start value; the block applies chain_length
// links and returns the 64-bit end value. Each link is worked in the shared
// a5/1 register set: a load step that gives the first keystream bit, then 63
// majority-clocking steps. The reset chain length is 2^21. One chain is worked
// at a time; the next start value is taken once the finished end value has
// moved to the output register, which holds it until taken. chain_length is
// written through cfg_wr_en / cfg_wr_data; the user must do so only while idle,
// the block itself does not enforce this.
module a51_rainbow_chain (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [a51rc_pkg::LEN_W-1:0]   cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [a51rc_pkg::VALUE_W-1:0] s_start_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [a51rc_pkg::VALUE_W-1:0] m_end_value
);

    a51rc_pkg::cmd_t             cmd;
    a51rc_pkg::sts_t             sts;
    logic [a51rc_pkg::LEN_W-1:0] chain_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_length_reg <= a51rc_pkg::LEN_RESET;
        end else if (cfg_wr_en) begin
            chain_length_reg <= cfg_wr_data;
        end
    end

    a51rc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    a51rc_datapath u_datapath (
        .aclk         (aclk),
        .cmd          (cmd),
        .sts          (sts),
        .start_value  (s_start_value),
        .chain_length (chain_length_reg),
        .end_value    (m_end_value)
    );

    // one chain at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a chain is in progress");

    // output register never overwritten while its transaction is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.store_out && m_valid && !m_ready))
        else $error("pending result overwritten");

    // a link is only started when links remain
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_link |-> !sts.n_zero)
        else $error("link started with none left");

endmodule

[dv/a51_chain_checker.sv]
// a51_chain_checker: predicts chain end values and compares them with the result channel
`timescale 1ns / 1ps

module a51_chain_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [a51rc_pkg::LEN_W-1:0]   cfg_wr_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [a51rc_pkg::VALUE_W-1:0] s_start_value,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [a51rc_pkg::VALUE_W-1:0] m_end_value,
    output int                            fails,
    output int                            ends_due
);

    logic [a51rc_pkg::LEN_W-1:0]   links_per_chain;
    logic [a51rc_pkg::VALUE_W-1:0] end_values_due[$];
    logic [a51rc_pkg::VALUE_W-1:0] wanted_end;

    // one link: load the three registers from the value, then 64 keystream bits
    function automatic logic [a51rc_pkg::VALUE_W-1:0] a51_link(
        input logic [a51rc_pkg::VALUE_W-1:0] v,
        input logic [a51rc_pkg::LEN_W-1:0]   n
    );
        logic [a51rc_pkg::R1_W-1:0]    r1;
        logic [a51rc_pkg::R2_W-1:0]    r2;
        logic [a51rc_pkg::R3_W-1:0]    r3;
        logic [a51rc_pkg::VALUE_W-1:0] n_wide;
        logic [a51rc_pkg::VALUE_W-1:0] keystream;
        logic                          c1, c2, c3, maj;
        n_wide    = a51rc_pkg::VALUE_W'(n);
        r1        = a51rc_pkg::R1_W'((v >> a51rc_pkg::R1_LSB) ^ n_wide);
        r2        = a51rc_pkg::R2_W'((v >> a51rc_pkg::R2_LSB) ^ n_wide);
        r3        = a51rc_pkg::R3_W'((v >> a51rc_pkg::R3_LSB) ^ n_wide);
        keystream = a51rc_pkg::VALUE_W'(r1[a51rc_pkg::R1_W-1] ^ r2[a51rc_pkg::R2_W-1]
                                        ^ r3[a51rc_pkg::R3_W-1]);
        for (int k = 1; k < a51rc_pkg::VALUE_W; k++) begin
            c1  = |(r1 & a51rc_pkg::R1_CLK);
            c2  = |(r2 & a51rc_pkg::R2_CLK);
            c3  = |(r3 & a51rc_pkg::R3_CLK);
            maj = (c1 & c2) | (c1 & c3) | (c2 & c3);
            if (c1 == maj) begin
                r1 = {r1[a51rc_pkg::R1_W-2:0], ^(r1 & a51rc_pkg::R1_FB)};
            end
            if (c2 == maj) begin
                r2 = {r2[a51rc_pkg::R2_W-2:0], ^(r2 & a51rc_pkg::R2_FB)};
            end
            if (c3 == maj) begin
                r3 = {r3[a51rc_pkg::R3_W-2:0], ^(r3 & a51rc_pkg::R3_FB)};
            end
            keystream = {keystream[a51rc_pkg::VALUE_W-2:0],
                         r1[a51rc_pkg::R1_W-1] ^ r2[a51rc_pkg::R2_W-1]
                         ^ r3[a51rc_pkg::R3_W-1]};
        end
        return keystream;
    endfunction

    // link numbers count down from the chain length minus one to zero
    function automatic logic [a51rc_pkg::VALUE_W-1:0] chain_end(
        input logic [a51rc_pkg::VALUE_W-1:0] start_point,
        input logic [a51rc_pkg::LEN_W-1:0]   links
    );
        logic [a51rc_pkg::VALUE_W-1:0] v;
        logic [a51rc_pkg::LEN_W-1:0]   n;
        v = start_point;
        n = links;
        while (n != '0) begin
            n = n - a51rc_pkg::LEN_W'(1);
            v = a51_link(v, n);
        end
        return v;
    endfunction

    initial begin
        fails    = 0;
        ends_due = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            links_per_chain <= a51rc_pkg::LEN_RESET;
        end else begin
            if (cfg_wr_en) begin
                links_per_chain <= cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                end_values_due.push_back(chain_end(s_start_value, links_per_chain));
            end
            if (m_valid && m_ready) begin
                if (end_values_due.size() == 0) begin
                    $error("end_value: expected none, actual %h", m_end_value);
                    fails = fails + 1;
                end else begin
                    wanted_end = end_values_due.pop_front();
                    if (m_end_value !== wanted_end) begin
                        $error("end_value: expected %h, actual %h", wanted_end, m_end_value);
                        fails = fails + 1;
                    end
                end
            end
        end
        ends_due <= end_values_due.size();
    end

    final begin
        if (end_values_due.size() != 0) begin
            $error("end_value: %0d expected transactions never arrived",
                   end_values_due.size());
        end
    end

endmodule

[dv/tb_top.sv]
// tb_top: stimulus, handshake idling and verdict for the a5/1 rainbow chain generator
`timescale 1ns / 1ps

module tb_top;

    localparam int QUIET_LIMIT  = 100000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 16;
    localparam int END_CYCLES   = 260;

    logic                          aclk;
    logic                          aresetn       = 1'b0;
    logic                          cfg_wr_en     = 1'b0;
    logic [a51rc_pkg::LEN_W-1:0]   cfg_wr_data   = '0;
    logic                          s_valid       = 1'b0;
    logic                          s_ready;
    logic [a51rc_pkg::VALUE_W-1:0] s_start_value = '0;
    logic                          m_valid;
    logic                          m_ready       = 1'b0;
    logic [a51rc_pkg::VALUE_W-1:0] m_end_value;

    int   fails;
    int   ends_due;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_left     = 0;
    logic hold_req      = 1'b0;
    logic hold_done     = 1'b0;
    int   quiet_cycles  = 0;
    int   chains_sent   = 0;

    a51_rainbow_chain dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_start_value (s_start_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_end_value   (m_end_value)
    );

    a51_chain_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_start_value (s_start_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_end_value   (m_end_value),
        .fails         (fails),
        .ends_due      (ends_due)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // result side: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [a51rc_pkg::VALUE_W-1:0] edge_value(input int i);
        logic [a51rc_pkg::VALUE_W-1:0] v;
        case (i % 8)
            0:       v = '0;
            1:       v = '1;
            2:       v = 64'd1;
            3:       v = 64'h8000_0000_0000_0000;
            4:       v = 64'hAAAA_AAAA_AAAA_AAAA;
            5:       v = 64'h5555_5555_5555_5555;
            6:       v = 64'h0000_2000_0040_0000;
            default: v = 64'h0000_1000_0080_0000;
        endcase
        return v;
    endfunction

    function automatic logic [a51rc_pkg::VALUE_W-1:0] random_value();
        logic [a51rc_pkg::VALUE_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = 64'd1 << $urandom_range(0, 63);
            1:       v = ~(64'd1 << $urandom_range(0, 63));
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    task automatic program_length(input logic [a51rc_pkg::LEN_W-1:0] len);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // valid stays up between back-to-back transactions
    task automatic offer_start(input logic [a51rc_pkg::VALUE_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_start_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        chains_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (ends_due != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [a51rc_pkg::LEN_W-1:0] len, input int count,
                             input bit edge_values);
        program_length(len);
        for (int i = 0; i < count; i++) begin
            offer_start(edge_values ? edge_value(i) : random_value());
        end
        drain();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        program_length(24'hFFFFFF);
        program_length(24'd8388608);

        set_idling(21, 53);
        run_phase(24'd0, 8, 1'b1);
        run_phase(24'd1, 8, 1'b1);
        run_phase(24'd2, 4, 1'b1);
        run_phase(24'd3, 15, 1'b0);
        run_phase(24'd0, 10, 1'b0);

        set_idling(53, 21);
        run_phase(24'd9, 15, 1'b0);
        run_phase(24'd64, 15, 1'b0);

        // output held off while the sender keeps offering
        set_idling(0, 0);
        hold_req <= 1'b1;
        run_phase(24'd1, 20, 1'b0);
        run_phase(24'd200, 10, 1'b0);
        run_phase(24'd31, 15, 1'b0);

        repeat (END_CYCLES) @(posedge aclk);
        @(negedge aclk);
        $display("summary: %0d chains checked at lengths 0 to 200, both sides stalling",
                 chains_sent);
        $display("summary: length register also written with all ones and 2^23");
        if (fails == 0 && ends_due == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/a51rc_pkg.sv
rtl/a51rc_ctrl.sv
rtl/a51rc_datapath.sv
rtl/a51_rainbow_chain.sv
dv/a51_chain_checker.sv
dv/tb_top.sv
